FILE: sv/hchm_pkg.sv
// ----------------------------------------------------------------------------
// hchm_pkg
// shared types and constants of the hour/code histogram monitor
// ----------------------------------------------------------------------------
package hchm_pkg;

    localparam int HOURS   = 25;
    localparam int CODES   = 100;
    localparam int CNT_W   = 32;
    localparam int THR_W   = 16;
    localparam int HOUR_AW = (HOURS > 1) ? $clog2(HOURS) : 1;
    localparam int CODE_AW = (CODES > 1) ? $clog2(CODES) : 1;
    localparam int CLR_N   = (HOURS > CODES) ? HOURS : CODES;
    localparam int CLR_AW  = (CLR_N > 1) ? $clog2(CLR_N) : 1;
    localparam logic [15:0] THR_RESET = 16'd60;

    typedef struct packed {
        logic [4:0] hour_of_day;
        logic [4:0] day_of_month;
        logic [7:0] code_value;
    } t_in;

    typedef struct packed {
        logic report_needed;
        logic day_rolled;
    } t_out;

    typedef enum logic {
        ALU_INC,
        ALU_CMP
    } t_alu_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_INC_H,
        S_INC_C,
        S_SCAN,
        S_SCAN_END,
        S_CLEAR,
        S_DONE
    } t_state;

    // table access request from the sequencer
    typedef struct packed {
        logic               h_re;
        logic [HOUR_AW-1:0] h_raddr;
        logic               h_we;
        logic [HOUR_AW-1:0] h_waddr;
        logic               c_re;
        logic [CODE_AW-1:0] c_raddr;
        logic               c_we;
        logic [CODE_AW-1:0] c_waddr;
        logic [CNT_W-1:0]   wdata;
    } t_tbl_req;

endpackage

FILE: sv/hchm_alu.sv
// ----------------------------------------------------------------------------
// hchm_alu
// shared 32-bit adder: counter increment or compare against threshold
// ----------------------------------------------------------------------------
module hchm_alu (
    input  hchm_pkg::t_alu_op             i_op,
    input  logic [hchm_pkg::CNT_W-1:0]    i_a,
    input  logic [hchm_pkg::THR_W-1:0]    i_thr,
    output logic [hchm_pkg::CNT_W-1:0]    o_sum,
    output logic                          o_above
);
    import hchm_pkg::*;

    logic [CNT_W-1:0] b_op;
    logic             cin;
    logic [CNT_W:0]   sum;

    // compare: a + ~b = a - b - 1, carry out set when a > b
    assign b_op = (i_op == ALU_CMP) ? ~{{(CNT_W-THR_W){1'b0}}, i_thr} : '0;
    assign cin  = (i_op == ALU_INC);
    assign sum  = {1'b0, i_a} + {1'b0, b_op} + {{CNT_W{1'b0}}, cin};

    assign o_sum   = sum[CNT_W-1:0];
    assign o_above = sum[CNT_W];

endmodule

FILE: sv/hchm_tables.sv
// ----------------------------------------------------------------------------
// hchm_tables
// hour and code counter memories with per-entry valid bits
// ----------------------------------------------------------------------------
module hchm_tables (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hchm_pkg::t_tbl_req            i_req,
    output logic [hchm_pkg::CNT_W-1:0]    o_h_rdata,
    output logic [hchm_pkg::CNT_W-1:0]    o_c_rdata
);
    import hchm_pkg::*;

    logic [CNT_W-1:0] hour_mem [HOURS];
    logic [CNT_W-1:0] code_mem [CODES];
    logic [HOURS-1:0] r_h_vld;
    logic [CODES-1:0] r_c_vld;
    logic [CNT_W-1:0] r_h_rd;
    logic [CNT_W-1:0] r_c_rd;
    logic             r_h_ok;
    logic             r_c_ok;

    always_ff @(posedge i_clk) begin
        if (i_req.h_we) begin
            hour_mem[i_req.h_waddr] <= i_req.wdata;
        end
        if (i_req.h_re) begin
            r_h_rd <= hour_mem[i_req.h_raddr];
        end
        if (i_req.c_we) begin
            code_mem[i_req.c_waddr] <= i_req.wdata;
        end
        if (i_req.c_re) begin
            r_c_rd <= code_mem[i_req.c_raddr];
        end
    end

    // never-written entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= '0;
            r_c_vld <= '0;
            r_h_ok  <= 1'b0;
            r_c_ok  <= 1'b0;
        end else begin
            if (i_req.h_we) begin
                r_h_vld[i_req.h_waddr] <= 1'b1;
            end
            if (i_req.h_re) begin
                r_h_ok <= r_h_vld[i_req.h_raddr];
            end
            if (i_req.c_we) begin
                r_c_vld[i_req.c_waddr] <= 1'b1;
            end
            if (i_req.c_re) begin
                r_c_ok <= r_c_vld[i_req.c_raddr];
            end
        end
    end

    assign o_h_rdata = r_h_ok ? r_h_rd : '0;
    assign o_c_rdata = r_c_ok ? r_c_rd : '0;

endmodule

FILE: sv/hchm_ctrl.sv
// ----------------------------------------------------------------------------
// hchm_ctrl
// sequencer: increment, day compare, hour scan and table clear sweep
// ----------------------------------------------------------------------------
module hchm_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  hchm_pkg::t_in                 i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output hchm_pkg::t_out                o_out,
    output hchm_pkg::t_tbl_req            o_req,
    output hchm_pkg::t_alu_op             o_alu_op,
    output logic                          o_alu_sel_code,
    input  logic [hchm_pkg::CNT_W-1:0]    i_alu_sum,
    input  logic                          i_alu_above
);
    import hchm_pkg::*;

    t_state             r_state, n_state;
    logic [HOUR_AW-1:0] r_hour_a;
    logic [CODE_AW-1:0] r_code_a;
    logic               r_hour_ok;
    logic               r_code_ok;
    logic [4:0]         r_last_day;
    logic               r_roll;
    logic               r_report;
    logic [HOUR_AW-1:0] r_idx;
    logic               r_pend;
    logic [CLR_AW-1:0]  r_cnt;
    logic               accept;
    logic               scan_last;
    logic               clr_last;
    logic               do_cmp;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign scan_last = (r_idx == HOUR_AW'(HOURS - 1));
    assign clr_last  = (r_cnt == CLR_AW'(CLR_N - 1));
    assign do_cmp    = ((r_state == S_SCAN) && r_pend) || (r_state == S_SCAN_END);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (i_in_valid) n_state = S_READ;
            S_READ:     n_state = S_INC_H;
            S_INC_H:    n_state = S_INC_C;
            S_INC_C:    n_state = r_roll ? S_SCAN : S_DONE;
            S_SCAN:     if (scan_last) n_state = S_SCAN_END;
            S_SCAN_END: n_state = S_CLEAR;
            S_CLEAR:    if (clr_last) n_state = S_DONE;
            S_DONE:     if (i_out_ready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_req          = '0;
        o_alu_op       = ALU_CMP;
        o_alu_sel_code = 1'b0;
        o_in_ready     = 1'b0;
        o_out_valid    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_READ: begin
                o_req.h_re    = r_hour_ok;
                o_req.h_raddr = r_hour_a;
                o_req.c_re    = r_code_ok;
                o_req.c_raddr = r_code_a;
            end
            S_INC_H: begin
                o_alu_op      = ALU_INC;
                o_req.h_we    = r_hour_ok;
                o_req.h_waddr = r_hour_a;
                o_req.wdata   = i_alu_sum;
            end
            S_INC_C: begin
                o_alu_op       = ALU_INC;
                o_alu_sel_code = 1'b1;
                o_req.c_we     = r_code_ok;
                o_req.c_waddr  = r_code_a;
                o_req.wdata    = i_alu_sum;
            end
            S_SCAN: begin
                o_req.h_re    = 1'b1;
                o_req.h_raddr = r_idx;
            end
            S_SCAN_END: begin
                o_alu_op = ALU_CMP;
            end
            S_CLEAR: begin
                o_req.h_we    = ({1'b0, r_cnt} < (CLR_AW + 1)'(HOURS));
                o_req.h_waddr = r_cnt[HOUR_AW-1:0];
                o_req.c_we    = ({1'b0, r_cnt} < (CLR_AW + 1)'(CODES));
                o_req.c_waddr = r_cnt[CODE_AW-1:0];
                o_req.wdata   = '0;
            end
            S_DONE: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_last_day <= '0;
            r_roll     <= 1'b0;
            r_report   <= 1'b0;
            r_pend     <= 1'b0;
            r_idx      <= '0;
            r_cnt      <= '0;
            r_hour_ok  <= 1'b0;
            r_code_ok  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_hour_ok  <= ({1'b0, i_in.hour_of_day} < 6'(HOURS));
                r_code_ok  <= ({1'b0, i_in.code_value} < 9'(CODES));
                r_roll     <= (r_last_day != 5'd0) && (r_last_day != i_in.day_of_month);
                r_last_day <= i_in.day_of_month;
                r_report   <= 1'b0;
            end
            if (r_state == S_INC_C) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
            end
            if (r_state == S_SCAN) begin
                r_pend <= 1'b1;
                r_idx  <= r_idx + 1'b1;
            end
            if (do_cmp && i_alu_above) begin
                r_report <= 1'b1;
            end
            if (r_state == S_SCAN_END) begin
                r_cnt <= '0;
            end
            if (r_state == S_CLEAR) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // address registers carry payload only
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hour_a <= i_in.hour_of_day[HOUR_AW-1:0];
            r_code_a <= i_in.code_value[CODE_AW-1:0];
        end
    end

    assign o_out.report_needed = r_report;
    assign o_out.day_rolled    = r_roll;

endmodule

FILE: sv/irq_hour_code_histogram_monitor.sv
// ----------------------------------------------------------------------------
// irq_hour_code_histogram_monitor
// per-hour and per-code event histogram with daily burst report
// ----------------------------------------------------------------------------
// sequence: a same-day event passes the read, hour increment and code increment
//   steps before its result; a day rollover adds the hour scan, final compare and clear sweep
// flow: one event at a time, next beat can be taken in the cycle after the result
//   beat; the hour scan and the clear sweep through the counter memories slow rollovers
// reset: synchronous active low; tables read as zero through valid bits,
//   stored day zero (no day seen), burst_threshold 60
module irq_hour_code_histogram_monitor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  hchm_pkg::t_in                 i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output hchm_pkg::t_out                o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hchm_pkg::THR_W-1:0]    i_cfg_data
);
    import hchm_pkg::*;

    logic [THR_W-1:0] r_thr;
    t_tbl_req         req;
    t_alu_op          alu_op;
    logic             alu_sel_code;
    logic [CNT_W-1:0] h_rdata;
    logic [CNT_W-1:0] c_rdata;
    logic [CNT_W-1:0] alu_a;
    logic [CNT_W-1:0] alu_sum;
    logic             alu_above;

    // threshold register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    // sequencer
    hchm_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in           (i_in),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out          (o_out),
        .o_req          (req),
        .o_alu_op       (alu_op),
        .o_alu_sel_code (alu_sel_code),
        .i_alu_sum      (alu_sum),
        .i_alu_above    (alu_above)
    );

    // counter memories
    hchm_tables u_tables (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .o_h_rdata (h_rdata),
        .o_c_rdata (c_rdata)
    );

    // one adder serves both increments and every scan compare
    assign alu_a = alu_sel_code ? c_rdata : h_rdata;

    hchm_alu u_alu (
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_thr   (r_thr),
        .o_sum   (alu_sum),
        .o_above (alu_above)
    );

endmodule

FILE: sv/hchm_checker.sv
// ----------------------------------------------------------------------------
// hchm_checker
// port-level checks of the histogram monitor
// ----------------------------------------------------------------------------
module hchm_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              o_in_ready,
    input  logic              o_out_valid,
    input  logic              i_out_ready,
    input  hchm_pkg::t_out    o_out
);
    import hchm_pkg::*;

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // one event in flight at a time
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready && !o_out_valid)
        else $error("input taken while busy");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("ready while result pending");

    // a report only comes with a rollover
    a_report_roll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.report_needed |-> o_out.day_rolled)
        else $error("report without rollover");

endmodule

bind irq_hour_code_histogram_monitor hchm_checker u_hchm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the hour/code histogram monitor: a behavioral
// predictor tracks the hour and code tables, the stored day and the burst
// threshold, and every result beat is compared with the oldest prediction
// ----------------------------------------------------------------------------
module testbench;
    import hchm_pkg::*;

    // clock, reset and block ports; the driven inputs are known from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in                   i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out                  o_out;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [THR_W-1:0]      i_cfg_data  = '0;

    // predictor state: mirror of the counter tables, stored day and threshold
    logic [CNT_W-1:0]      hour_tally [HOURS];
    logic [CNT_W-1:0]      code_tally [CODES];
    logic [4:0]            seen_day;
    logic [THR_W-1:0]      burst_limit;

    // predicted flags, oldest first
    t_out                  pending_flags [$];

    // run bookkeeping
    bit                    steady      = 1'b0;  // no idling on either side
    int                    mismatches  = 0;
    int                    events_sent = 0;
    int                    flags_seen  = 0;
    int                    rollovers   = 0;
    int                    bursts      = 0;

    irq_hour_code_histogram_monitor i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // period of two time units
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    task automatic clear_tallies();
        foreach (hour_tally[i]) hour_tally[i] = '0;
        foreach (code_tally[i]) code_tally[i] = '0;
    endtask

    // counts first, then the day compare; a rollover scans the hour table
    // (including this event's own count) and wipes both tables
    function automatic t_out histogram_update(input t_in ev);
        t_out res;
        res = '0;
        if (int'(ev.hour_of_day) < HOURS)
            hour_tally[ev.hour_of_day] = hour_tally[ev.hour_of_day] + 1'b1;
        if (int'(ev.code_value) < CODES)
            code_tally[ev.code_value] = code_tally[ev.code_value] + 1'b1;
        if (seen_day != 5'd0 && seen_day != ev.day_of_month) begin
            foreach (hour_tally[i])
                if (hour_tally[i] > CNT_W'(burst_limit))
                    res.report_needed = 1'b1;
            foreach (hour_tally[i]) hour_tally[i] = '0;
            foreach (code_tally[i]) code_tally[i] = '0;
            res.day_rolled = 1'b1;
        end
        // day zero is kept as is, so the next event counts as a first one
        seen_day = ev.day_of_month;
        return res;
    endfunction

    function automatic t_in make_event(input int hour, input int day, input int code);
        t_in ev;
        ev.hour_of_day  = 5'(hour);
        ev.day_of_month = 5'(day);
        ev.code_value   = 8'(code);
        return ev;
    endfunction

    // ------------------------------------------------------------------------
    // mismatch reporting
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // input side: one beat per call, valid held across back-to-back beats
    // ------------------------------------------------------------------------
    task automatic send_event(input t_in ev);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in       <= ev;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        // beat taken at this edge: predict now, before its result can appear
        pending_flags.push_back(histogram_update(ev));
        events_sent++;
    endtask

    // drop valid and wait until every predicted result has come back
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_flags.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // threshold writes only while the block has nothing in flight
    task automatic write_threshold(input logic [THR_W-1:0] value);
        wait_idle();
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        burst_limit = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // output side: random stall before each result beat
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = steady ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // every result beat against the oldest prediction, field by field
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            flags_seen++;
            if (o_out.day_rolled) rollovers++;
            if (o_out.report_needed) bursts++;
            if (pending_flags.size() == 0) begin
                report_mismatch($sformatf("result beat %0d with nothing expected",
                                          flags_seen));
            end else begin
                want = pending_flags.pop_front();
                if (o_out.report_needed !== want.report_needed)
                    report_mismatch($sformatf("beat %0d report_needed %b, expected %b",
                                              flags_seen, o_out.report_needed,
                                              want.report_needed));
                if (o_out.day_rolled !== want.day_rolled)
                    report_mismatch($sformatf("beat %0d day_rolled %b, expected %b",
                                              flags_seen, o_out.day_rolled,
                                              want.day_rolled));
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // first event, table edges, out-of-range hour and code, day zero
    task automatic test_first_events();
        send_event(make_event(0, 7, 0));       // first event: day stored only
        send_event(make_event(24, 7, 99));     // last valid hour and code
        send_event(make_event(25, 7, 100));    // both just out of range
        send_event(make_event(31, 7, 255));    // field maxima
        send_event(make_event(3, 8, 5));       // day change, nothing above 60
        send_event(make_event(3, 0, 5));       // day zero still rolls over
        send_event(make_event(3, 31, 5));      // after day zero: first event again
        send_event(make_event(3, 31, 5));
        send_event(make_event(3, 1, 5));       // rollover from day 31 to 1
    endtask

    // reset threshold of 60: 61 hits in one hour report, 60 do not
    task automatic test_reset_threshold_burst();
        send_event(make_event(31, 20, 200));
        repeat (61) send_event(make_event(12, 20, $urandom_range(0, 255)));
        send_event(make_event(31, 21, 200));   // report expected
        repeat (60) send_event(make_event(12, 21, $urandom_range(0, 255)));
        send_event(make_event(31, 22, 200));   // exactly at the limit: quiet
    endtask

    // threshold extremes and the strict compare at one
    task automatic test_threshold_edges();
        write_threshold(16'd0);
        send_event(make_event(31, 3, 0));
        send_event(make_event(5, 3, 0));       // single hit above zero
        send_event(make_event(31, 4, 0));      // report expected
        send_event(make_event(31, 4, 200));    // no hour counted
        send_event(make_event(31, 5, 0));      // empty table: quiet rollover
        write_threshold(16'hFFFF);
        send_event(make_event(9, 5, 1));
        send_event(make_event(9, 5, 1));
        send_event(make_event(9, 6, 1));       // never above the maximum
        write_threshold(16'd1);
        send_event(make_event(10, 6, 2));
        send_event(make_event(10, 6, 2));
        send_event(make_event(31, 7, 2));      // two above one: report
        send_event(make_event(11, 7, 2));
        send_event(make_event(31, 8, 2));      // one is not above one
    endtask

    // day runs with random content: hits cluster on a hot hour so that
    // reports fire for small thresholds, plus stray days and day zero
    task automatic test_random_days();
        int phase_start;
        int run_len;
        int day;
        int hot;
        int hour;
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0:       write_threshold(16'd0);
                1:       write_threshold(16'hFFFF);
                2, 7:    write_threshold(16'd60);
                5:       write_threshold(THR_W'($urandom_range(0, 65535)));
                default: write_threshold(THR_W'($urandom_range(1, 12)));
            endcase
            steady = ($urandom_range(0, 3) == 0);
            phase_start = events_sent;
            while (events_sent - phase_start < 120) begin
                day     = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 31);
                run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 80)
                                                      : $urandom_range(1, 30);
                hot     = $urandom_range(0, 31);
                repeat (run_len) begin
                    hour = ($urandom_range(0, 3) != 0) ? hot : $urandom_range(0, 31);
                    // occasional stray day breaks the run
                    if ($urandom_range(0, 19) == 0)
                        send_event(make_event(hour, $urandom_range(0, 31),
                                              $urandom_range(0, 255)));
                    else
                        send_event(make_event(hour, day, $urandom_range(0, 255)));
                end
            end
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        clear_tallies();
        seen_day    = 5'd0;
        burst_limit = THR_RESET;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_first_events();
        test_reset_threshold_burst();
        test_threshold_edges();
        test_random_days();

        // drain, then wait past the length of a full rollover for strays
        wait_idle();
        repeat (140) @(negedge i_clk);
        if (pending_flags.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_flags.size()));

        $display("sent %0d events, checked %0d results", events_sent, flags_seen);
        $display("saw %0d day rollovers, %0d of them with a burst report",
                 rollovers, bursts);
        if (mismatches == 0) begin
            $display("irq_hour_code_histogram_monitor test passed");
        end else begin
            $display("irq_hour_code_histogram_monitor test failed");
        end
        $finish;
    end

    // watchdog: far beyond the slowest correct run
    initial begin
        #4000000;
        $display("timeout waiting for the block");
        $display("irq_hour_code_histogram_monitor test failed");
        $finish;
    end

endmodule
